### hdl/lri_pkg.sv
// Shared types and constants of the line rasterizer.
// No dependencies; every other file of the block but lri_mul refers to it by scoped names.
package lri_pkg;

  // Fixed field widths
  localparam int WIN_W    = 13;
  localparam int BPP_W    = 6;
  localparam int STRIDE_W = 15;
  localparam int OFF_W    = 26;
  localparam int COLOR_W  = 3;
  localparam int CHAN_W   = 8;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_LSB = 2;

  typedef enum logic [1:0] {
    REG_WINDOW_WIDTH   = 2'd0,
    REG_WINDOW_HEIGHT  = 2'd1,
    REG_BITS_PER_PIXEL = 2'd2,
    REG_LINE_STRIDE    = 2'd3
  } reg_idx_t;

  localparam logic [WIN_W-1:0]    RST_WINDOW_WIDTH   = 13'd1024;
  localparam logic [WIN_W-1:0]    RST_WINDOW_HEIGHT  = 13'd768;
  localparam logic [BPP_W-1:0]    RST_BITS_PER_PIXEL = 6'd32;
  localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE    = 15'd4096;

  // Request operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Fixed palette, {red, green, blue}; entry seven is black
  localparam logic [3*CHAN_W-1:0] PALETTE [8] = '{
    24'hFF0000, 24'hF8F879, 24'h00FF00, 24'h4FF857,
    24'h00BFFF, 24'h808080, 24'hFFFFFF, 24'h000000
  };

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/lri_in_if.sv
// Request channel of the line rasterizer: valid/ready plus the load or step fields.
// Depends on lri_pkg for the colour index width.
interface lri_in_if #(
  parameter int COORD_BITS = 13
);
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic signed [COORD_BITS-1:0]   x_start;
  logic signed [COORD_BITS-1:0]   y_start;
  logic signed [COORD_BITS-1:0]   x_end;
  logic signed [COORD_BITS-1:0]   y_end;
  logic [lri_pkg::COLOR_W-1:0]    color_index;

  modport source (
    output valid, operation, x_start, y_start, x_end, y_end, color_index,
    input  ready
  );
  modport sink (
    input  valid, operation, x_start, y_start, x_end, y_end, color_index,
    output ready
  );
endinterface

### hdl/lri_out_if.sv
// Pixel channel of the line rasterizer: valid/ready plus one pixel result.
// Depends on lri_pkg for the offset and colour widths.
interface lri_out_if #(
  parameter int COORD_BITS = 13
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS:0]    pix_x;
  logic signed [COORD_BITS-1:0]  pix_y;
  logic [lri_pkg::OFF_W-1:0]     byte_offset;
  logic [lri_pkg::CHAN_W-1:0]    red;
  logic [lri_pkg::CHAN_W-1:0]    green;
  logic [lri_pkg::CHAN_W-1:0]    blue;
  logic                          in_window;
  logic                          last;

  modport source (
    output valid, pix_x, pix_y, byte_offset, red, green, blue, in_window, last,
    input  ready
  );
  modport sink (
    input  valid, pix_x, pix_y, byte_offset, red, green, blue, in_window, last,
    output ready
  );
endinterface

### hdl/lri_mul.sv
// Shared unsigned multiplier of the line rasterizer, product registered.
// No package dependency; operands are chosen by the sequencer in the top level.
module lri_mul #(
  parameter int MUL_W = 15
) (
  input  logic               clk,
  input  logic [MUL_W-1:0]   op_a,
  input  logic [MUL_W-1:0]   op_b,
  output logic [2*MUL_W-1:0] prod
);

  // Register the product every cycle
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

### hdl/lri_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lri_pkg for the status struct. The quotient must fit in MAG_W bits.
module lri_div #(
  parameter int MAG_W = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2*MAG_W-1:0]     numer,
  input  logic [MAG_W-1:0]       denom,
  output logic [MAG_W-1:0]       quot,
  output lri_pkg::div_stat_t     stat
);

  localparam int CNT_W = (MAG_W > 1) ? $clog2(MAG_W) : 1;

  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] quo;
  logic [MAG_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [MAG_W:0]   shifted;
  logic [MAG_W:0]   trial;
  logic             fits;

  // Shift in the next numerator bit and try the subtraction
  always_comb begin
    shifted = {rem, quo[MAG_W-1]};
    fits    = shifted >= {1'b0, den};
    trial   = shifted - {1'b0, den};
  end

  // Count the iterations, flag completion for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Load the upper half as partial remainder, then develop one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= numer[2*MAG_W-1:MAG_W];
      quo <= numer[MAG_W-1:0];
      den <= denom;
    end else if (busy) begin
      rem <= fits ? trial[MAG_W-1:0] : shifted[MAG_W-1:0];
      quo <= {quo[MAG_W-2:0], fits};
    end
  end

  assign quot      = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### hdl/line_rasterizer_interp_top.sv
// Line rasterizer with divided interpolation: a load request latches two endpoints and a
// colour, each step request returns one pixel of the line with its frame-buffer byte offset,
// window flag, palette colour and last flag. One request is handled at a time. A load, or a
// step with no line loaded, returns nothing and leaves the block ready for the next request.
// A step that returns a pixel holds off further requests until its pixel is taken; it passes
// through the shared divider, which develops one quotient bit per cycle over COORD_BITS + 1
// bits, and through the single shared multiplier for the interpolation product and the two
// byte-offset products. No clearing pass after reset.
// Depends on lri_pkg, lri_in_if, lri_out_if, lri_mul and lri_div.
module line_rasterizer_interp_top #(
  parameter int COORD_BITS = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lri_pkg::PADDR_W-1:0]   paddr,
  input  logic [lri_pkg::PDATA_W-1:0]   pwdata,
  output logic [lri_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  lri_in_if.sink                        cmd,
  lri_out_if.source                     pixel
);

  localparam int POS_W  = COORD_BITS + 1;
  localparam int MAG_W  = COORD_BITS + 1;
  localparam int DIFF_W = COORD_BITS + 2;
  localparam int NUM_W  = 2 * MAG_W;
  localparam int MUL_W  = (MAG_W > lri_pkg::STRIDE_W) ? MAG_W : lri_pkg::STRIDE_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CMP_W  = (POS_W > lri_pkg::WIN_W) ? POS_W : lri_pkg::WIN_W;
  localparam int OFF_W  = lri_pkg::OFF_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_DSTART = 9'b000000100,
    S_DIV    = 9'b000001000,
    S_FIX    = 9'b000010000,
    S_MULX   = 9'b000100000,
    S_MULY   = 9'b001000000,
    S_SUM    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  // ---------------------------------------------------------------- configuration
  logic [lri_pkg::WIN_W-1:0]    window_width;
  logic [lri_pkg::WIN_W-1:0]    window_height;
  logic [lri_pkg::BPP_W-1:0]    bits_per_pixel;
  logic [lri_pkg::STRIDE_W-1:0] line_stride;
  logic                         cfg_wr;
  lri_pkg::reg_idx_t            reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = lri_pkg::reg_idx_t'(paddr[lri_pkg::REG_LSB+1:lri_pkg::REG_LSB]);

  // Write the selected register in the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      window_width   <= lri_pkg::RST_WINDOW_WIDTH;
      window_height  <= lri_pkg::RST_WINDOW_HEIGHT;
      bits_per_pixel <= lri_pkg::RST_BITS_PER_PIXEL;
      line_stride    <= lri_pkg::RST_LINE_STRIDE;
    end else if (cfg_wr) begin
      case (reg_sel)
        lri_pkg::REG_WINDOW_WIDTH:   window_width   <= pwdata[lri_pkg::WIN_W-1:0];
        lri_pkg::REG_WINDOW_HEIGHT:  window_height  <= pwdata[lri_pkg::WIN_W-1:0];
        lri_pkg::REG_BITS_PER_PIXEL: bits_per_pixel <= pwdata[lri_pkg::BPP_W-1:0];
        lri_pkg::REG_LINE_STRIDE:    line_stride    <= pwdata[lri_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    case (reg_sel)
      lri_pkg::REG_WINDOW_WIDTH:   prdata = lri_pkg::PDATA_W'(window_width);
      lri_pkg::REG_WINDOW_HEIGHT:  prdata = lri_pkg::PDATA_W'(window_height);
      lri_pkg::REG_BITS_PER_PIXEL: prdata = lri_pkg::PDATA_W'(bits_per_pixel);
      lri_pkg::REG_LINE_STRIDE:    prdata = lri_pkg::PDATA_W'(line_stride);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- line state
  logic signed [POS_W-1:0]      end_a_x;
  logic signed [COORD_BITS-1:0] end_a_y;
  logic signed [POS_W-1:0]      end_b_x;
  logic signed [COORD_BITS-1:0] end_b_y;
  logic                         x_major;
  logic signed [POS_W-1:0]      cur_pos;
  logic signed [POS_W-1:0]      stop_pos;
  logic                         line_active;
  logic [lri_pkg::COLOR_W-1:0]  line_color;

  logic cmd_acc;
  logic is_load;
  logic is_step;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign is_load   = cmd_acc && (cmd.operation == lri_pkg::OP_LOAD);
  assign is_step   = cmd_acc && (cmd.operation == lri_pkg::OP_STEP);

  // Load: nudge a vertical line, pick the major axis from |dy| < 2|dx|
  logic signed [POS_W-1:0]  ld_ax;
  logic signed [POS_W-1:0]  ld_bx_raw;
  logic signed [POS_W-1:0]  ld_bx;
  logic signed [POS_W-1:0]  ld_ay;
  logic signed [POS_W-1:0]  ld_by;
  logic signed [DIFF_W-1:0] ld_dx;
  logic signed [DIFF_W-1:0] ld_dy;
  logic [DIFF_W-1:0]        ld_abs_dx;
  logic [DIFF_W-1:0]        ld_abs_dy;
  logic                     ld_xmaj;
  logic signed [POS_W-1:0]  ld_cur;
  logic signed [POS_W-1:0]  ld_stop;

  always_comb begin
    ld_ax     = {cmd.x_start[COORD_BITS-1], cmd.x_start};
    ld_bx_raw = {cmd.x_end[COORD_BITS-1], cmd.x_end};
    ld_bx     = (cmd.x_start == cmd.x_end) ? ld_bx_raw + POS_W'(1) : ld_bx_raw;
    ld_ay     = {cmd.y_start[COORD_BITS-1], cmd.y_start};
    ld_by     = {cmd.y_end[COORD_BITS-1], cmd.y_end};
    ld_dx     = {ld_bx[POS_W-1], ld_bx} - {ld_ax[POS_W-1], ld_ax};
    ld_dy     = {ld_by[POS_W-1], ld_by} - {ld_ay[POS_W-1], ld_ay};
    ld_abs_dx = ld_dx[DIFF_W-1] ? -ld_dx : ld_dx;
    ld_abs_dy = ld_dy[DIFF_W-1] ? -ld_dy : ld_dy;
    ld_xmaj   = {1'b0, ld_abs_dy} < {ld_abs_dx, 1'b0};
    if (ld_xmaj) begin
      ld_cur  = (ld_ax < ld_bx) ? ld_ax : ld_bx;
      ld_stop = (ld_ax < ld_bx) ? ld_bx : ld_ax;
    end else begin
      ld_cur  = (ld_ay < ld_by) ? ld_ay : ld_by;
      ld_stop = (ld_ay < ld_by) ? ld_by : ld_ay;
    end
  end

  // Step: choose base point, minor delta and major delta for the interpolation
  logic signed [DIFF_W-1:0] eax;
  logic signed [DIFF_W-1:0] eay;
  logic signed [DIFF_W-1:0] ebx;
  logic signed [DIFF_W-1:0] eby;
  logic signed [DIFF_W-1:0] ecur;
  logic signed [DIFF_W-1:0] base_minor;
  logic signed [DIFF_W-1:0] base_major;
  logic signed [DIFF_W-1:0] d_minor;
  logic signed [DIFF_W-1:0] d_major;
  logic signed [DIFF_W-1:0] t_major;
  logic [DIFF_W-1:0]        abs_minor;
  logic [DIFF_W-1:0]        abs_major;
  logic [DIFF_W-1:0]        abs_t;
  logic                     q_neg;

  always_comb begin
    eax  = {end_a_x[POS_W-1], end_a_x};
    ebx  = {end_b_x[POS_W-1], end_b_x};
    eay  = {{2{end_a_y[COORD_BITS-1]}}, end_a_y};
    eby  = {{2{end_b_y[COORD_BITS-1]}}, end_b_y};
    ecur = {cur_pos[POS_W-1], cur_pos};
    if (x_major) begin
      if (end_a_x <= end_b_x) begin
        base_minor = eay; base_major = eax; d_minor = eby - eay; d_major = ebx - eax;
      end else begin
        base_minor = eby; base_major = ebx; d_minor = eay - eby; d_major = eax - ebx;
      end
    end else begin
      if (end_a_y >= end_b_y) begin
        base_minor = eax; base_major = eay; d_minor = ebx - eax; d_major = eby - eay;
      end else begin
        base_minor = ebx; base_major = eby; d_minor = eax - ebx; d_major = eay - eby;
      end
    end
    t_major   = ecur - base_major;
    abs_minor = d_minor[DIFF_W-1] ? -d_minor : d_minor;
    abs_major = d_major[DIFF_W-1] ? -d_major : d_major;
    abs_t     = t_major[DIFF_W-1] ? -t_major : t_major;
    q_neg     = d_minor[DIFF_W-1] ^ t_major[DIFF_W-1] ^ d_major[DIFF_W-1];
  end

  // ---------------------------------------------------------------- shared units
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic               div_start;
  logic [MAG_W-1:0]   div_q;
  lri_pkg::div_stat_t div_stat;

  // Pixel result registers
  logic signed [POS_W-1:0]      px;
  logic signed [COORD_BITS-1:0] py;
  logic [OFF_W-1:0]             x_term;
  logic [OFF_W-1:0]             byte_offset;
  logic                         in_window;
  logic                         last;
  logic                         win_c;

  // Steer the multiplier by sequencer state
  always_comb begin
    case (state)
      S_MUL: begin
        mul_a = MUL_W'(abs_minor[MAG_W-1:0]);
        mul_b = MUL_W'(abs_t[MAG_W-1:0]);
      end
      S_MULX: begin
        mul_a = MUL_W'($unsigned(px));
        mul_b = MUL_W'(bits_per_pixel);
      end
      S_MULY: begin
        mul_a = MUL_W'($unsigned(py));
        mul_b = MUL_W'(line_stride);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lri_mul #(.MUL_W(MUL_W)) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  assign div_start = (state == S_DSTART);

  lri_div #(.MAG_W(MAG_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (mul_p[NUM_W-1:0]),
    .denom (abs_major[MAG_W-1:0]),
    .quot  (div_q),
    .stat  (div_stat)
  );

  // Signed quotient added to the base minor coordinate
  logic signed [DIFF_W-1:0] q_mag;
  logic signed [DIFF_W-1:0] minor;

  always_comb begin
    q_mag = {1'b0, div_q};
    minor = base_minor + (q_neg ? -q_mag : q_mag);
  end

  always_comb begin
    win_c = !px[POS_W-1] && !py[COORD_BITS-1]
            && (CMP_W'($unsigned(px)) < CMP_W'(window_width))
            && (CMP_W'($unsigned(py)) < CMP_W'(window_height));
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (is_step && line_active) state_next = S_MUL;
      S_MUL:    state_next = S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV:    if (div_stat.done) state_next = S_FIX;
      S_FIX:    state_next = S_MULX;
      S_MULX:   state_next = S_MULY;
      S_MULY:   state_next = S_SUM;
      S_SUM:    state_next = S_OUT;
      S_OUT:    if (pixel.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Advance the sequencer, track whether a line is in progress
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      line_active <= 1'b0;
    end else begin
      state <= state_next;
      if (is_load) begin
        line_active <= 1'b1;
      end else if (state == S_FIX && cur_pos >= stop_pos) begin
        line_active <= 1'b0;
      end
    end
  end

  // Latch a new line, build one pixel per step
  always_ff @(posedge clk) begin
    if (is_load) begin
      end_a_x    <= ld_ax;
      end_a_y    <= cmd.y_start;
      end_b_x    <= ld_bx;
      end_b_y    <= cmd.y_end;
      line_color <= cmd.color_index;
      x_major    <= ld_xmaj;
      cur_pos    <= ld_cur;
      stop_pos   <= ld_stop;
    end
    case (state)
      S_FIX: begin
        if (x_major) begin
          px <= cur_pos;
          py <= minor[COORD_BITS-1:0];
        end else begin
          px <= minor[POS_W-1:0];
          py <= cur_pos[COORD_BITS-1:0];
        end
        last <= (cur_pos >= stop_pos);
        if (cur_pos < stop_pos) begin
          cur_pos <= cur_pos + POS_W'(1);
        end
      end
      S_MULX: in_window   <= win_c;
      S_MULY: x_term      <= mul_p[OFF_W+2:3];
      S_SUM:  byte_offset <= in_window ? x_term + mul_p[OFF_W-1:0] : '0;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- pixel channel
  assign pixel.valid       = (state == S_OUT);
  assign pixel.pix_x       = px;
  assign pixel.pix_y       = py;
  assign pixel.byte_offset = byte_offset;
  assign pixel.red         = lri_pkg::PALETTE[line_color][3*lri_pkg::CHAN_W-1:2*lri_pkg::CHAN_W];
  assign pixel.green       = lri_pkg::PALETTE[line_color][2*lri_pkg::CHAN_W-1:lri_pkg::CHAN_W];
  assign pixel.blue        = lri_pkg::PALETTE[line_color][lri_pkg::CHAN_W-1:0];
  assign pixel.in_window   = in_window;
  assign pixel.last        = last;

`ifndef SYNTH
  // No new request while a pixel waits
  a_busy_while_pending: assert property (@(posedge clk) disable iff (rst)
    pixel.valid |-> !cmd.ready)
    else $error("request accepted while a pixel is pending");

  // Start the divider only when it is free
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // After the last pixel is taken, no line is active
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready && pixel.last) |=> !line_active)
    else $error("line still active after its last pixel");

  // Clipped pixels carry no offset
  a_clip_offset: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && !pixel.in_window) |-> (pixel.byte_offset == '0))
    else $error("offset set on a clipped pixel");
`endif

endmodule
